/* sv/slit_pkg.sv */
// ----------------------------------------------------------------------------
// slit_pkg: shared types and constants of the seen-line interval tracker
// Operation and status codes, default sizes, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package slit_pkg;

   localparam int FILE_SLOTS_DEF    = 8;
   localparam int MAX_INTERVALS_DEF = 16;
   localparam int LINE_BITS_DEF     = 20;

   localparam int OP_BITS     = 2;
   localparam int SLOT_BITS   = 3;
   localparam int STAMP_BITS  = 64;
   localparam int STATUS_BITS = 2;

   typedef enum logic [OP_BITS-1:0] {
      OP_ADD       = 2'd0,
      OP_QUERY     = 2'd1,
      OP_CLEAR_SLOT = 2'd2,
      OP_CLEAR_ALL = 2'd3
   } op_type;

   localparam logic [STATUS_BITS-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_INVALID = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL    = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic prep;
      logic rd;
      logic chk;
      logic mv_init;
      logic mv_rd;
      logic mv_wr;
      logic put;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_scan;
      logic is_add;
      logic scan_end;
      logic chk_stop;
      logic full;
      logic mv_done;
   } dp_stat_type;

endpackage

/* sv/slit_ctrl.sv */
// ----------------------------------------------------------------------------
// slit_ctrl: request sequencer
// Steps one request through prepare, scan, shift and write-back.
// ----------------------------------------------------------------------------
module slit_ctrl import slit_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output dp_cmd_type  cmd,
   input  dp_stat_type stat
);

   typedef enum logic [3:0] {
      S_IDLE, S_PREP, S_SCAN_RD, S_SCAN_CHK, S_FINAL, S_MV_RD, S_MV_WR, S_PUT, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, req_ready_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      req_ready_in = req_ready_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load     = 1'b1;
               req_ready_in = 1'b0;
               state_in     = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            if (stat.need_scan) begin
               state_in = S_SCAN_RD;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = S_DONE;
            end
         end
         S_SCAN_RD: begin
            if (stat.scan_end) begin
               state_in = S_FINAL;
            end else begin
               cmd.rd   = 1'b1;
               state_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            cmd.chk  = 1'b1;
            state_in = stat.chk_stop ? S_FINAL : S_SCAN_RD;
         end
         S_FINAL: begin
            cmd.mv_init = 1'b1;
            if (!stat.is_add || stat.full) begin
               rsp_valid_in = 1'b1;
               state_in     = S_DONE;
            end else begin
               state_in = S_MV_RD;
            end
         end
         S_MV_RD: begin
            if (stat.mv_done) begin
               state_in = S_PUT;
            end else begin
               cmd.mv_rd = 1'b1;
               state_in  = S_MV_WR;
            end
         end
         S_MV_WR: begin
            cmd.mv_wr = 1'b1;
            state_in  = S_MV_RD;
         end
         S_PUT: begin
            cmd.put      = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               req_ready_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* sv/slit_dp.sv */
// ----------------------------------------------------------------------------
// slit_dp: interval store and merge datapath
// Holds stamps, counts and the interval memory; scans, shifts and writes.
// ----------------------------------------------------------------------------
module slit_dp import slit_pkg::*; #(
   parameter int FILE_SLOTS    = FILE_SLOTS_DEF,
   parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
   parameter int LINE_BITS     = LINE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dp_cmd_type             cmd,
   output dp_stat_type            stat,
   input  logic [OP_BITS-1:0]     req_operation,
   input  logic [SLOT_BITS-1:0]   req_file_slot,
   input  logic [LINE_BITS-1:0]   req_from_line,
   input  logic [LINE_BITS-1:0]   req_to_line,
   input  logic [STAMP_BITS-1:0]  req_version_stamp,
   output logic                   rsp_covered,
   output logic [STATUS_BITS-1:0] rsp_status
);

   localparam int SIW   = (FILE_SLOTS > 1) ? $clog2(FILE_SLOTS) : 1;
   localparam int IW    = $clog2(MAX_INTERVALS + 1);
   localparam int DEPTH = FILE_SLOTS * MAX_INTERVALS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [LINE_BITS-1:0]  mem_start [DEPTH];
   logic [LINE_BITS-1:0]  mem_end   [DEPTH];

   logic [STAMP_BITS-1:0] stamps_ff [FILE_SLOTS];
   logic [IW-1:0]         counts_ff [FILE_SLOTS];

   op_type                op_ff;
   logic [SIW-1:0]        slot_ff;
   logic [LINE_BITS-1:0]  lo_ff, hi_ff;
   logic [STAMP_BITS-1:0] stamp_ff;
   logic                  bad_ff, empty_ff;
   logic [IW-1:0]         cnt_ff, idx_ff, k_ff, m_ff, src_ff, rem_ff;
   logic [LINE_BITS-1:0]  rd_start_ff, rd_end_ff;
   logic                  covered_ff;
   logic [STATUS_BITS-1:0] status_ff;

   logic [LINE_BITS-1:0]  lo_in, hi_in;
   logic                  slot_ok, one_zero, both_zero;
   logic                  mismatch, is_below, is_touch;
   logic [IW:0]           new_count;
   logic [IW-1:0]         dst;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic                  wr_en;
   logic [LINE_BITS-1:0]  wr_start, wr_end;

   function automatic logic [AW-1:0] addr_of(input logic [SIW-1:0] s, input logic [IW-1:0] i);
      return AW'(int'(s) * MAX_INTERVALS + int'(i));
   endfunction

   // normalize the incoming range
   always_comb begin
      both_zero = (req_from_line == '0) && (req_to_line == '0);
      one_zero  = !both_zero && ((req_from_line == '0) || (req_to_line == '0));
      if (req_to_line < req_from_line) begin
         lo_in = req_to_line;
         hi_in = req_from_line;
      end else begin
         lo_in = req_from_line;
         hi_in = req_to_line;
      end
      slot_ok = int'(req_file_slot) < FILE_SLOTS;
   end

   assign mismatch  = (stamp_ff != '0) && (stamps_ff[slot_ff] != '0)
                      && (stamps_ff[slot_ff] != stamp_ff);
   assign is_below  = (m_ff == '0) && (({1'b0, rd_end_ff} + 1'b1) < {1'b0, lo_ff});
   assign is_touch  = {1'b0, rd_start_ff} <= ({1'b0, hi_ff} + 1'b1);
   assign new_count = {1'b0, cnt_ff} + 1'b1 - {1'b0, m_ff};
   assign dst       = IW'({1'b0, src_ff} + 1'b1 - {1'b0, m_ff});

   always_comb begin
      stat.need_scan = !bad_ff && !empty_ff
                       && ((op_ff == OP_ADD) || ((op_ff == OP_QUERY) && !mismatch));
      stat.is_add    = (op_ff == OP_ADD);
      stat.scan_end  = (idx_ff == cnt_ff);
      stat.full      = new_count > (IW+1)'(MAX_INTERVALS);
      stat.mv_done   = (rem_ff == '0);
      if (op_ff == OP_QUERY) begin
         stat.chk_stop = (lo_ff < rd_start_ff) || (lo_ff <= rd_end_ff);
      end else begin
         stat.chk_stop = !is_below && !is_touch;
      end
   end

   assign rd_addr  = cmd.mv_rd ? addr_of(slot_ff, src_ff) : addr_of(slot_ff, idx_ff);
   assign wr_en    = cmd.mv_wr || cmd.put;
   assign wr_addr  = cmd.put ? addr_of(slot_ff, k_ff) : addr_of(slot_ff, dst);
   assign wr_start = cmd.put ? lo_ff : rd_start_ff;
   assign wr_end   = cmd.put ? hi_ff : rd_end_ff;

   // interval memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_start[wr_addr] <= wr_start;
         mem_end[wr_addr]   <= wr_end;
      end
      if (cmd.rd || cmd.mv_rd) begin
         rd_start_ff <= mem_start[rd_addr];
         rd_end_ff   <= mem_end[rd_addr];
      end
   end

   // per-slot stamps and counts
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < FILE_SLOTS; s++) begin
            stamps_ff[s] <= '0;
            counts_ff[s] <= '0;
         end
      end else if (cmd.prep) begin
         if (op_ff == OP_CLEAR_ALL) begin
            for (int s = 0; s < FILE_SLOTS; s++) begin
               stamps_ff[s] <= '0;
               counts_ff[s] <= '0;
            end
         end else if (!bad_ff && (op_ff == OP_CLEAR_SLOT)) begin
            stamps_ff[slot_ff] <= '0;
            counts_ff[slot_ff] <= '0;
         end else if (!bad_ff && (op_ff == OP_ADD) && (stamp_ff != '0)
                      && (stamps_ff[slot_ff] != stamp_ff)) begin
            stamps_ff[slot_ff] <= stamp_ff;
            if (stamps_ff[slot_ff] != '0) begin
               counts_ff[slot_ff] <= '0;
            end
         end
      end else if (cmd.put) begin
         counts_ff[slot_ff] <= IW'(new_count);
      end
   end

   // request registers and scan state
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= op_type'(req_operation);
         slot_ff  <= SIW'(req_file_slot);
         lo_ff    <= lo_in;
         hi_ff    <= hi_in;
         stamp_ff <= req_version_stamp;
         empty_ff <= both_zero;
         bad_ff   <= (req_operation != OP_CLEAR_ALL) && (!slot_ok
                     || (((req_operation == OP_ADD) || (req_operation == OP_QUERY))
                         && one_zero));
      end
      if (cmd.prep) begin
         covered_ff <= (op_ff == OP_QUERY) && !bad_ff && empty_ff;
         status_ff  <= bad_ff ? STATUS_INVALID : STATUS_OK;
         idx_ff     <= '0;
         k_ff       <= '0;
         m_ff       <= '0;
         if ((op_ff == OP_ADD) && (stamp_ff != '0) && (stamps_ff[slot_ff] != stamp_ff)
             && (stamps_ff[slot_ff] != '0)) begin
            cnt_ff <= '0;
         end else begin
            cnt_ff <= counts_ff[slot_ff];
         end
      end
      if (cmd.chk) begin
         idx_ff <= idx_ff + 1'b1;
         if (op_ff == OP_QUERY) begin
            if (!(lo_ff < rd_start_ff) && (lo_ff <= rd_end_ff)) begin
               covered_ff <= (hi_ff <= rd_end_ff);
            end
         end else if (is_below) begin
            k_ff <= k_ff + 1'b1;
         end else if (is_touch) begin
            m_ff <= m_ff + 1'b1;
            if (rd_start_ff < lo_ff) lo_ff <= rd_start_ff;
            if (rd_end_ff > hi_ff)   hi_ff <= rd_end_ff;
         end
      end
      if (cmd.mv_init) begin
         rem_ff <= cnt_ff - k_ff - m_ff;
         src_ff <= (m_ff == '0) ? cnt_ff - 1'b1 : k_ff + m_ff;
         if ((op_ff == OP_ADD) && stat.full) begin
            status_ff <= STATUS_FULL;
         end
      end
      if (cmd.mv_wr) begin
         rem_ff <= rem_ff - 1'b1;
         src_ff <= (m_ff == '0) ? src_ff - 1'b1 : src_ff + 1'b1;
      end
   end

   assign rsp_covered = covered_ff;
   assign rsp_status  = status_ff;

endmodule

/* sv/seen_line_interval_tracker_top.sv */
// ----------------------------------------------------------------------------
// seen_line_interval_tracker_top: per-file seen-line interval tracker
// Keeps a stamp and a sorted set of disjoint line intervals per file slot;
// adds coalesce ranges into the set, queries test single-interval coverage.
// ----------------------------------------------------------------------------
//
//  channel   ports                                         direction
//  request   req_valid/req_ready, operation, slot, lines,  in
//            version stamp
//  response  rsp_valid/rsp_ready, covered, status          out
//
// One request is in flight at a time. A request that needs no scan passes
// through accept, prepare and respond; a scan adds a read and a check per
// stored interval read, a read that runs past the last one, and a final step
// to settle. A stored add also reads and writes each interval shifted, then
// ends the shift and writes back; one memory access per cycle with a
// registered read sets this. Reset clears all stamps and counts at once; the
// interval memory needs no clearing. A stalled response holds the block.
module seen_line_interval_tracker_top import slit_pkg::*; #(
   parameter int FILE_SLOTS    = FILE_SLOTS_DEF,
   parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
   parameter int LINE_BITS     = LINE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [OP_BITS-1:0]     req_operation,
   input  logic [SLOT_BITS-1:0]   req_file_slot,
   input  logic [LINE_BITS-1:0]   req_from_line,
   input  logic [LINE_BITS-1:0]   req_to_line,
   input  logic [STAMP_BITS-1:0]  req_version_stamp,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_covered,
   output logic [STATUS_BITS-1:0] rsp_status
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequence the request
   slit_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // hold the sets and do the merge work
   slit_dp #(
      .FILE_SLOTS    (FILE_SLOTS),
      .MAX_INTERVALS (MAX_INTERVALS),
      .LINE_BITS     (LINE_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_operation     (req_operation),
      .req_file_slot     (req_file_slot),
      .req_from_line     (req_from_line),
      .req_to_line       (req_to_line),
      .req_version_stamp (req_version_stamp),
      .rsp_covered       (rsp_covered),
      .rsp_status        (rsp_status)
   );

endmodule

/* sv/slit_checker.sv */
// ----------------------------------------------------------------------------
// slit_checker: port-level checks of the interval tracker
// Watches the request and response ports over time.
// ----------------------------------------------------------------------------
module slit_checker import slit_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_covered,
   input logic [STATUS_BITS-1:0] rsp_status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_covered))
      else $error("response changed while stalled");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a response is pending");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after a request");

   a_covered_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_covered |-> rsp_status == STATUS_OK)
      else $error("covered with a failing status");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == STATUS_OK || rsp_status == STATUS_INVALID
                    || rsp_status == STATUS_FULL)
      else $error("unknown status code");

endmodule

bind seen_line_interval_tracker_top slit_checker u_slit_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_covered (rsp_covered),
   .rsp_status  (rsp_status)
);

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the seen-line interval tracker
// Drives add, query and clear requests with random idles on both sides,
// predicts each response from a local interval-set model per slot, and
// compares covered and status in order.
// ----------------------------------------------------------------------------
module tb_top;
   import slit_pkg::*;

   localparam int SLOTS = FILE_SLOTS_DEF;
   localparam int MAXIV = MAX_INTERVALS_DEF;
   localparam int LB    = LINE_BITS_DEF;
   localparam logic [LB-1:0] LMAX = '1;

   typedef struct packed {
      op_type          op;
      logic [2:0]      slot;
      logic [LB-1:0]   lo;
      logic [LB-1:0]   hi;
      logic [63:0]     stamp;
   } request_type;

   typedef struct packed {
      logic            covered;
      logic [1:0]      status;
   } answer_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [OP_BITS-1:0] req_operation = '0;
   logic [SLOT_BITS-1:0] req_file_slot = '0;
   logic [LB-1:0] req_from_line = '0;
   logic [LB-1:0] req_to_line = '0;
   logic [STAMP_BITS-1:0] req_version_stamp = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic rsp_covered;
   logic [STATUS_BITS-1:0] rsp_status;

   seen_line_interval_tracker_top u_top (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // model state: stamp and sorted disjoint intervals per slot
   logic [63:0]   mdl_stamp [SLOTS];
   logic [LB-1:0] mdl_start [SLOTS][MAXIV];
   logic [LB-1:0] mdl_end   [SLOTS][MAXIV];
   int            mdl_count [SLOTS];

   request_type pending_requests[$];
   answer_type  expected_answers[$];
   int errors = 0;
   int send_idle = 9, recv_idle = 65;
   bit hold_sender = 0;

   // merge [lo,hi] into slot s; return status
   function automatic logic [1:0] merge_range(int s, logic [LB-1:0] lo, logic [LB-1:0] hi);
      logic [LB-1:0] ns [MAXIV+1];
      logic [LB-1:0] ne [MAXIV+1];
      int i, n;
      i = 0; n = 0;
      while (i < mdl_count[s] && {1'b0, mdl_end[s][i]} + 1 < {1'b0, lo}) begin
         ns[n] = mdl_start[s][i]; ne[n] = mdl_end[s][i]; n++; i++;
      end
      while (i < mdl_count[s] && {1'b0, mdl_start[s][i]} <= {1'b0, hi} + 1) begin
         if (mdl_start[s][i] < lo) lo = mdl_start[s][i];
         if (mdl_end[s][i] > hi) hi = mdl_end[s][i];
         i++;
      end
      ns[n] = lo; ne[n] = hi; n++;
      while (i < mdl_count[s]) begin
         if (n > MAXIV) return STATUS_FULL;
         ns[n] = mdl_start[s][i]; ne[n] = mdl_end[s][i]; n++; i++;
      end
      if (n > MAXIV) return STATUS_FULL;
      for (int k = 0; k < n; k++) begin
         mdl_start[s][k] = ns[k]; mdl_end[s][k] = ne[k];
      end
      mdl_count[s] = n;
      return STATUS_OK;
   endfunction

   function automatic answer_type predict_answer(request_type r);
      answer_type a;
      logic [LB-1:0] lo, hi, t;
      int s;
      a = '0;
      lo = r.lo; hi = r.hi; s = r.slot;
      if (r.op == OP_CLEAR_ALL) begin
         for (int k = 0; k < SLOTS; k++) begin
            mdl_stamp[k] = '0; mdl_count[k] = 0;
         end
      end else if (s >= SLOTS) begin
         a.status = STATUS_INVALID;
      end else if (r.op == OP_CLEAR_SLOT) begin
         mdl_stamp[s] = '0; mdl_count[s] = 0;
      end else if ((lo == 0) != (hi == 0)) begin
         a.status = STATUS_INVALID;
      end else begin
         if (hi < lo) begin
            t = lo; lo = hi; hi = t;
         end
         if (r.op == OP_QUERY) begin
            if (lo == 0) a.covered = 1;
            else if (!(r.stamp != 0 && mdl_stamp[s] != 0 && mdl_stamp[s] != r.stamp)) begin
               for (int k = 0; k < mdl_count[s]; k++) begin
                  if (lo < mdl_start[s][k]) break;
                  if (lo <= mdl_end[s][k]) begin
                     a.covered = hi <= mdl_end[s][k];
                     break;
                  end
               end
            end
         end else begin
            if (r.stamp != 0 && mdl_stamp[s] != r.stamp) begin
               if (mdl_stamp[s] != 0) mdl_count[s] = 0;
               mdl_stamp[s] = r.stamp;
            end
            if (lo != 0) a.status = merge_range(s, lo, hi);
         end
      end
      return a;
   endfunction

   function automatic request_type make_request(op_type op, int slot, int lo, int hi,
                                                logic [63:0] stamp);
      request_type r;
      r.op = op; r.slot = 3'(slot); r.lo = LB'(lo); r.hi = LB'(hi); r.stamp = stamp;
      return r;
   endfunction

   // append a request to the pending list
   task automatic queue_request(request_type r);
      pending_requests.insert(pending_requests.size(), r);
   endtask

   // random line from a small window so intervals collide and coalesce
   function automatic logic [LB-1:0] rand_line();
      case ($urandom_range(0, 9))
         0: return LMAX - LB'($urandom_range(0, 3));
         1: return LB'($urandom_range(0, 3));
         2: return LB'($urandom);
         default: return LB'($urandom_range(1, 120));
      endcase
   endfunction

   function automatic request_type rand_request();
      request_type r;
      int k;
      k = $urandom_range(0, 99);
      r.op = k < 55 ? OP_ADD : k < 93 ? OP_QUERY : k < 98 ? OP_CLEAR_SLOT : OP_CLEAR_ALL;
      r.slot = 3'($urandom_range(0, 7));
      r.lo = rand_line();
      r.hi = rand_line();
      k = $urandom_range(0, 9);
      r.stamp = k < 6 ? 64'd0 : k < 9 ? 64'($urandom_range(1, 3)) : {$urandom, $urandom};
      return r;
   endfunction

   // Driver: advance the head request when accepted; hold otherwise.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else if (!req_valid || req_ready) begin
         if (pending_requests.size() > 0 && !hold_sender &&
             $urandom_range(0, 99) >= send_idle) begin
            request_type r;
            r = pending_requests.pop_front();
            expected_answers.insert(expected_answers.size(), predict_answer(r));
            req_valid <= 1;
            req_operation <= r.op;
            req_file_slot <= r.slot;
            req_from_line <= r.lo;
            req_to_line <= r.hi;
            req_version_stamp <= r.stamp;
         end else begin
            req_valid <= 0;
         end
      end
   end

   // Monitor: compare each response with the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_answers.size() == 0) begin
               $error("unexpected response covered=%0d status=%0d", rsp_covered, rsp_status);
               errors++;
            end else begin
               answer_type e;
               e = expected_answers.pop_front();
               if (rsp_covered !== e.covered) begin
                  $error("covered expected %0d actual %0d", e.covered, rsp_covered);
                  errors++;
               end
               if (rsp_status !== e.status) begin
                  $error("status expected %0d actual %0d", e.status, rsp_status);
                  errors++;
               end
            end
         end
         rsp_ready <= $urandom_range(0, 99) >= recv_idle;
      end
   end

   initial begin
      for (int k = 0; k < SLOTS; k++) begin
         mdl_stamp[k] = '0; mdl_count[k] = 0;
      end
      repeat (9) @(posedge clock);
      reset <= 0;

      // directed: empty range, invalid ends, reversal, touching, extremes
      queue_request(make_request(OP_QUERY, 0, 0, 0, 0));
      queue_request(make_request(OP_ADD, 0, 0, 5, 0));
      queue_request(make_request(OP_QUERY, 0, 7, 0, 0));
      queue_request(make_request(OP_ADD, 0, 10, 5, 64'd1));
      queue_request(make_request(OP_ADD, 0, 11, 20, 0));
      queue_request(make_request(OP_QUERY, 0, 5, 20, 0));
      queue_request(make_request(OP_QUERY, 0, 5, 20, 64'd2));
      queue_request(make_request(OP_ADD, 0, 0, 0, 64'd2));
      queue_request(make_request(OP_QUERY, 0, 5, 6, 64'd2));
      queue_request(make_request(OP_ADD, 1, 1, 1, '1));
      queue_request(make_request(OP_ADD, 1, LMAX, LMAX - 1, 0));
      queue_request(make_request(OP_QUERY, 1, LMAX, 1, '1));
      // fill slot 2 past capacity with separated lines
      for (int k = 0; k < 17; k++)
         queue_request(make_request(OP_ADD, 2, 3 * k + 1, 3 * k + 1, 0));
      queue_request(make_request(OP_ADD, 2, 2, 3, 0));
      queue_request(make_request(OP_CLEAR_SLOT, 0, 0, 0, 0));
      queue_request(make_request(OP_QUERY, 0, 5, 6, 0));
      queue_request(make_request(OP_CLEAR_ALL, 7, 0, 0, 0));
      queue_request(make_request(OP_QUERY, 1, 1, 1, 0));

      for (int phase = 0; phase < 3; phase++) begin
         for (int k = 0; k < 670; k++) queue_request(rand_request());
         wait (pending_requests.size() == 0);
         // drain fully before changing the idle mix
         hold_sender = 1;
         wait (expected_answers.size() == 0 && !req_valid);
         hold_sender = 0;
         if (phase == 0) begin
            send_idle = 65; recv_idle = 9;
         end else begin
            send_idle = 0; recv_idle = 0;
         end
      end
      repeat (200) @(posedge clock);
      if (errors == 0 && expected_answers.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end
endmodule

/* filelist.f */
sv/slit_pkg.sv
sv/slit_ctrl.sv
sv/slit_dp.sv
sv/seen_line_interval_tracker_top.sv
sv/slit_checker.sv
verif/tb_top.sv
